/* design/gcdt_pkg.sv */
// ----------------------------------------------------------------------------
// gcdt_pkg: shared definitions for the gnss clock drift tracker
// widths, register indexes, constants, serial unit request types and states
// ----------------------------------------------------------------------------
package gcdt_pkg;

  localparam int TIME_W     = 32;
  localparam int SEC_W      = 32;
  localparam int USEC_W     = 20;
  localparam int DRIFT_W    = 32;
  localparam int TOL_W      = 31;
  localparam int OFFSET_W   = 32;
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W = 32;

  // serial multiplier: signed a times unsigned b, one bit of b a cycle
  localparam int MUL_A_W = 33;
  localparam int MUL_B_W = 32;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W - 1 + 1;
  localparam int MUL_CNT_W = $clog2(MUL_B_W);

  // serial restoring divider: one quotient bit a cycle
  localparam int DIV_R_W    = 32;
  localparam int DIV_N_W    = 33;
  localparam int DIV_Q_W    = 33;
  localparam int DIV_STEP_W = 6;

  localparam logic [DIV_STEP_W-1:0] RATIO_DIV_STEPS = 6'd33;
  localparam logic [DIV_STEP_W-1:0] TEN_DIV_STEPS   = 6'd32;
  localparam logic [DIV_STEP_W-1:0] SEC_DIV_STEPS   = 6'd16;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_DRIFT_TOLERANCE = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_INITIAL_DRIFT   = 1'b1;

  // item kinds
  localparam logic ACTION_REFERENCE = 1'b0;
  localparam logic ACTION_QUERY     = 1'b1;

  localparam logic [TOL_W-1:0]   TOL_RESET   = 31'd1073742;
  localparam logic [DRIFT_W-1:0] Q_ONE       = 32'd1073741824;
  localparam logic [DRIFT_W-1:0] DRIFT_RESET = Q_ONE;
  localparam logic [31:0]        USEC_PER_SEC = 32'd1000000;
  localparam logic [31:0]        DIV_TEN      = 32'd10;
  localparam logic [35:0]        DRIFT_ROUND  = 36'd5;
  localparam logic [31:0]        S32_MAX      = 32'h7FFF_FFFF;
  localparam logic [31:0]        S32_MIN      = 32'h8000_0000;

  typedef struct packed {
    logic                      start;
    logic signed [MUL_A_W-1:0] a;
    logic [MUL_B_W-1:0]        b;
  } gcdt_mul_req_t;

  typedef struct packed {
    logic                      done;
    logic signed [MUL_P_W-1:0] product;
  } gcdt_mul_rsp_t;

  typedef struct packed {
    logic                  start;
    logic [DIV_R_W-1:0]    rem_init;
    logic [DIV_N_W-1:0]    num;
    logic [DIV_R_W-1:0]    den;
    logic [DIV_STEP_W-1:0] steps;
  } gcdt_div_req_t;

  typedef struct packed {
    logic               done;
    logic [DIV_Q_W-1:0] quo;
    logic [DIV_R_W-1:0] rem;
  } gcdt_div_rsp_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SETUP,
    S_RMUL,
    S_RSTART,
    S_RDIV,
    S_RQ,
    S_RTOL,
    S_RSUM,
    S_R10,
    S_R10W,
    S_QMUL,
    S_QT,
    S_QDIV,
    S_PUT
  } gcdt_state_t;

endpackage

/* design/gcdt_if.sv */
// ----------------------------------------------------------------------------
// gcdt_if: stream channels of the gnss clock drift tracker
// sample channel (reference or query beats) and result channel
// ----------------------------------------------------------------------------
interface gcdt_sample_if;
  import gcdt_pkg::*;

  logic              valid;
  logic              ready;
  logic              action;
  logic [TIME_W-1:0] local_time;
  logic [SEC_W-1:0]  ref_sec;
  logic [USEC_W-1:0] ref_usec;

  modport source (output valid, output action, output local_time, output ref_sec,
                  output ref_usec, input ready);
  modport sink (input valid, input action, input local_time, input ref_sec,
                input ref_usec, output ready);
endinterface

interface gcdt_result_if;
  import gcdt_pkg::*;

  logic                       valid;
  logic                       ready;
  logic [SEC_W-1:0]           est_sec;
  logic [USEC_W-1:0]          est_usec;
  logic signed [OFFSET_W-1:0] offset_usec;
  logic [DRIFT_W-1:0]         drift_now;

  modport source (output valid, output est_sec, output est_usec, output offset_usec,
                  output drift_now, input ready);
  modport sink (input valid, input est_sec, input est_usec, input offset_usec,
                input drift_now, output ready);
endinterface

/* design/gcdt_serial_mul.sv */
// ----------------------------------------------------------------------------
// gcdt_serial_mul: shift-add multiplier
// signed a times unsigned b, one bit of b retired per cycle
// ----------------------------------------------------------------------------
module gcdt_serial_mul (
  input  logic                    clk,
  input  logic                    rst,
  input  gcdt_pkg::gcdt_mul_req_t req,
  output gcdt_pkg::gcdt_mul_rsp_t rsp
);
  import gcdt_pkg::*;

  logic                      busy;
  logic                      done;
  logic [MUL_CNT_W-1:0]      cnt;
  logic signed [MUL_A_W-1:0] a;
  logic signed [MUL_A_W:0]   hi;
  logic [MUL_B_W-1:0]        lo;

  logic signed [MUL_A_W:0]   addend;
  logic signed [MUL_A_W:0]   sum;

  always_comb begin
    addend = lo[0] ? {a[MUL_A_W-1], a} : '0;
    sum    = hi + addend;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == '0);
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= MUL_CNT_W'(MUL_B_W - 1);
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
        end
        cnt <= cnt - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      a  <= req.a;
      hi <= '0;
      lo <= req.b;
    end else if (busy) begin
      hi <= {sum[MUL_A_W], sum[MUL_A_W:1]};
      lo <= {sum[0], lo[MUL_B_W-1:1]};
    end
  end

  assign rsp.done    = done;
  assign rsp.product = {hi[MUL_A_W-1:0], lo};

endmodule

/* design/gcdt_serial_div.sv */
// ----------------------------------------------------------------------------
// gcdt_serial_div: restoring divider
// one quotient bit per cycle, remainder seeded by the caller
// ----------------------------------------------------------------------------
module gcdt_serial_div (
  input  logic                    clk,
  input  logic                    rst,
  input  gcdt_pkg::gcdt_div_req_t req,
  output gcdt_pkg::gcdt_div_rsp_t rsp
);
  import gcdt_pkg::*;

  logic                  busy;
  logic                  done;
  logic [DIV_STEP_W-1:0] cnt;
  logic [DIV_R_W-1:0]    rem;
  logic [DIV_N_W-1:0]    num;
  logic [DIV_R_W-1:0]    den;
  logic [DIV_Q_W-1:0]    quo;

  logic [DIV_R_W+1:0]    trial;
  logic                  fits;

  // remainder stays below the divisor, so the shifted value needs one extra bit
  always_comb begin
    trial = {1'b0, rem, num[DIV_N_W-1]} - {2'b00, den};
    fits  = !trial[DIV_R_W+1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == '0);
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= req.steps - 1'b1;
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
        end
        cnt <= cnt - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= req.rem_init;
      num <= req.num;
      den <= req.den;
      quo <= '0;
    end else if (busy) begin
      rem <= fits ? trial[DIV_R_W-1:0] : {rem[DIV_R_W-2:0], num[DIV_N_W-1]};
      num <= {num[DIV_N_W-2:0], 1'b0};
      quo <= {quo[DIV_Q_W-2:0], fits};
    end
  end

  assign rsp.done = done;
  assign rsp.quo  = quo;
  assign rsp.rem  = rem;

endmodule

/* design/gnss_clock_drift_tracker_core.sv */
// ----------------------------------------------------------------------------
// gnss_clock_drift_tracker_core: disciplines a local microsecond count to gnss
// reference beats update anchors, offset and drift; query beats extrapolate
// ----------------------------------------------------------------------------
// One sample beat is worked on at a time, through a shift-add multiplier and a
// restoring divider that each retire one bit per cycle. A reference beat runs
// seconds times one million, then the drift ratio divide (the old-drift offset
// product runs alongside it), then the divide by ten of the drift blend (skipped
// when the blend saturates), with setup and bookkeeping states in between. A
// query beat runs drift times elapsed count, then the divide by one million. The
// result sits in an output register, so the next sample beat is taken while it
// waits. Drift is unsigned Q2.30. Writing initial_drift also loads the live drift.
// Configuration is expected only while no beat is in flight.
// ----------------------------------------------------------------------------
module gnss_clock_drift_tracker_core (
  input  logic                                clk,
  input  logic                                rst,
  gcdt_sample_if.sink                         sample,
  gcdt_result_if.source                       result,
  input  logic                                cfg_en,
  input  logic [gcdt_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [gcdt_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import gcdt_pkg::*;

  gcdt_state_t state;
  gcdt_state_t state_next;

  // configuration and tracking state
  logic [TOL_W-1:0]           tol;
  logic [TIME_W-1:0]          local_anchor;
  logic [SEC_W-1:0]           anchor_sec;
  logic [USEC_W-1:0]          anchor_usec;
  logic [DRIFT_W-1:0]         drift;
  logic signed [OFFSET_W-1:0] last_offset;

  // captured sample beat
  logic              it_action;
  logic [TIME_W-1:0] it_local;
  logic [SEC_W-1:0]  it_sec;
  logic [USEC_W-1:0] it_usec;

  // working registers
  logic [TIME_W-1:0]          dl;
  logic signed [USEC_W:0]     du;
  logic [35:0]                nine_old;
  logic signed [31:0]         dg;
  logic                       ovf;
  logic                       neg_q;
  logic signed [33:0]         q_s;
  logic signed [OFFSET_W-1:0] off_new;
  logic                       cand_ok;
  logic signed [37:0]         sum;
  logic [DRIFT_W-1:0]         drift_new;
  logic [SEC_W-1:0]           est_sec_r;
  logic [USEC_W-1:0]          est_usec_r;

  // output register
  logic                       res_valid;
  logic [SEC_W-1:0]           res_sec;
  logic [USEC_W-1:0]          res_usec;
  logic signed [OFFSET_W-1:0] res_offset;
  logic [DRIFT_W-1:0]         res_drift;

  // serial units
  gcdt_mul_req_t mul_req;
  gcdt_mul_rsp_t mul_rsp;
  gcdt_div_req_t div_req;
  gcdt_div_rsp_t div_rsp;

  logic in_ready;
  logic out_load;

  gcdt_serial_mul u_mul (
    .clk (clk),
    .rst (rst),
    .req (mul_req),
    .rsp (mul_rsp)
  );

  gcdt_serial_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // ---------------------------------------------------------------------------
  // arithmetic between the serial passes
  // ---------------------------------------------------------------------------
  logic [TIME_W-1:0]  local_diff;
  logic [SEC_W-1:0]   sec_diff;
  logic signed [52:0] dg_wide;
  logic signed [31:0] dg_sat;
  logic [31:0]        dg_mag;
  logic [31:0]        dl_mag;
  logic               p_neg;
  logic               p_round;
  logic signed [36:0] off_wide;
  logic signed [31:0] off_sat;
  logic signed [34:0] dev;
  logic signed [34:0] tol_s;
  logic signed [37:0] cand;
  logic               sum_sat;
  logic [34:0]        t_query;

  always_comb begin
    local_diff = it_local - local_anchor;
    sec_diff   = it_sec - anchor_sec;

    // global difference in microseconds, clamped to 32-bit signed
    dg_wide = $signed(mul_rsp.product[52:0]) + $signed({{32{du[USEC_W]}}, du});
    if ((&dg_wide[52:31]) || !(|dg_wide[52:31])) begin
      dg_sat = dg_wide[31:0];
    end else begin
      dg_sat = dg_wide[52] ? S32_MIN : S32_MAX;
    end

    dg_mag = dg[31] ? (32'd0 - dg) : dg;
    dl_mag = dl[31] ? (32'd0 - dl) : dl;

    // old drift times local difference, truncated toward zero after the q30 shift
    p_neg    = mul_rsp.product[MUL_P_W-1];
    p_round  = p_neg && (|mul_rsp.product[29:0]);
    off_wide = $signed({{5{dg[31]}}, dg})
             - $signed({{2{p_neg}}, mul_rsp.product[MUL_P_W-1:30]})
             - $signed({36'd0, p_round});
    if ((&off_wide[36:31]) || !(|off_wide[36:31])) begin
      off_sat = off_wide[31:0];
    end else begin
      off_sat = off_wide[36] ? S32_MIN : S32_MAX;
    end

    // deviation of the measured ratio from one
    dev   = $signed({q_s[33], q_s}) - $signed({3'b000, Q_ONE});
    tol_s = $signed({4'b0000, tol});

    cand    = cand_ok ? $signed({{4{q_s[33]}}, q_s}) : $signed({6'd0, drift});
    // a negative blend saturates just the same as an oversized one
    sum_sat = sum[37] || (sum[36:32] >= DIV_TEN[4:0]);

    t_query = {15'd0, anchor_usec} + {1'b0, mul_rsp.product[63:30]};
  end

  // ---------------------------------------------------------------------------
  // next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (sample.valid) begin
          state_next = S_SETUP;
        end
      end
      S_SETUP: begin
        state_next = (it_action == ACTION_QUERY) ? S_QMUL : S_RMUL;
      end
      S_RMUL: begin
        if (mul_rsp.done) begin
          state_next = S_RSTART;
        end
      end
      S_RSTART: begin
        state_next = S_RDIV;
      end
      // the ratio divide runs longer than the offset product, so its done covers both
      S_RDIV: begin
        if (div_rsp.done) begin
          state_next = S_RQ;
        end
      end
      S_RQ: begin
        state_next = S_RTOL;
      end
      S_RTOL: begin
        state_next = S_RSUM;
      end
      S_RSUM: begin
        state_next = S_R10;
      end
      S_R10: begin
        state_next = sum_sat ? S_PUT : S_R10W;
      end
      S_R10W: begin
        if (div_rsp.done) begin
          state_next = S_PUT;
        end
      end
      S_QMUL: begin
        if (mul_rsp.done) begin
          state_next = S_QT;
        end
      end
      S_QT: begin
        state_next = S_QDIV;
      end
      S_QDIV: begin
        if (div_rsp.done) begin
          state_next = S_PUT;
        end
      end
      S_PUT: begin
        if (!res_valid || result.ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // control outputs and serial unit requests
  // ---------------------------------------------------------------------------
  always_comb begin
    in_ready = 1'b0;
    out_load = 1'b0;
    mul_req  = '0;
    div_req  = '0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
      end
      S_SETUP: begin
        mul_req.start = 1'b1;
        if (it_action == ACTION_QUERY) begin
          mul_req.a = $signed({1'b0, local_diff});
          mul_req.b = drift;
        end else begin
          mul_req.a = $signed({sec_diff[SEC_W-1], sec_diff});
          mul_req.b = USEC_PER_SEC;
        end
      end
      S_RSTART: begin
        // ratio: |dg| * 2^30 / |dl|, seeded with the top bits of the dividend
        div_req.start    = 1'b1;
        div_req.rem_init = {3'b000, dg_mag[31:3]};
        div_req.num      = {dg_mag[2:0], 30'd0};
        div_req.den      = dl_mag;
        div_req.steps    = RATIO_DIV_STEPS;
        mul_req.start    = 1'b1;
        mul_req.a        = $signed({dl[TIME_W-1], dl});
        mul_req.b        = drift;
      end
      S_R10: begin
        if (!sum_sat) begin
          div_req.start    = 1'b1;
          div_req.rem_init = {27'd0, sum[36:32]};
          div_req.num      = {sum[31:0], 1'b0};
          div_req.den      = DIV_TEN;
          div_req.steps    = TEN_DIV_STEPS;
        end
      end
      S_QT: begin
        div_req.start    = 1'b1;
        div_req.rem_init = {13'd0, t_query[34:16]};
        div_req.num      = {t_query[15:0], 17'd0};
        div_req.den      = USEC_PER_SEC;
        div_req.steps    = SEC_DIV_STEPS;
      end
      S_PUT: begin
        out_load = !res_valid || result.ready;
      end
      default: begin
      end
    endcase
  end

  assign sample.ready = in_ready;

  // ---------------------------------------------------------------------------
  // control registers, tracking state and configuration
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      res_valid    <= 1'b0;
      tol          <= TOL_RESET;
      local_anchor <= '0;
      anchor_sec   <= '0;
      anchor_usec  <= '0;
      drift        <= DRIFT_RESET;
      last_offset  <= '0;
    end else begin
      state <= state_next;

      if (out_load) begin
        res_valid <= 1'b1;
      end else if (result.ready) begin
        res_valid <= 1'b0;
      end

      // a reference beat moves the anchors once its result is posted
      if (out_load && (it_action == ACTION_REFERENCE)) begin
        local_anchor <= it_local;
        anchor_sec   <= it_sec;
        anchor_usec  <= it_usec;
        drift        <= drift_new;
        last_offset  <= off_new;
      end

      if (cfg_en) begin
        unique case (cfg_index)
          CFG_DRIFT_TOLERANCE: tol   <= cfg_data[TOL_W-1:0];
          CFG_INITIAL_DRIFT:   drift <= cfg_data[DRIFT_W-1:0];
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // datapath registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (in_ready && sample.valid) begin
      it_action <= sample.action;
      it_local  <= sample.local_time;
      it_sec    <= sample.ref_sec;
      it_usec   <= sample.ref_usec;
    end

    case (state)
      S_SETUP: begin
        dl       <= local_diff;
        du       <= $signed({1'b0, it_usec}) - $signed({1'b0, anchor_usec});
        nine_old <= {drift, 3'b000} + {4'd0, drift} + DRIFT_ROUND;
      end
      S_RMUL: begin
        if (mul_rsp.done) begin
          dg <= dg_sat;
        end
      end
      S_RSTART: begin
        // a ratio of 2^33 or more is far outside any tolerance
        ovf   <= {3'b000, dg_mag} >= {dl_mag, 3'b000};
        neg_q <= dg[31] ^ dl[TIME_W-1];
      end
      S_RQ: begin
        q_s     <= neg_q ? -$signed({1'b0, div_rsp.quo}) : $signed({1'b0, div_rsp.quo});
        off_new <= off_sat;
      end
      S_RTOL: begin
        cand_ok <= !ovf && (dl != '0) && (dev <= tol_s) && (dev >= -tol_s);
      end
      S_RSUM: begin
        sum <= $signed({2'b00, nine_old}) + cand;
      end
      S_R10: begin
        if (sum_sat) begin
          drift_new <= '1;
        end
      end
      S_R10W: begin
        if (div_rsp.done) begin
          drift_new <= div_rsp.quo[DRIFT_W-1:0];
        end
      end
      S_QDIV: begin
        if (div_rsp.done) begin
          est_sec_r  <= anchor_sec + {16'd0, div_rsp.quo[15:0]};
          est_usec_r <= div_rsp.rem[USEC_W-1:0];
        end
      end
      default: begin
      end
    endcase

    if (out_load) begin
      if (it_action == ACTION_QUERY) begin
        res_sec    <= est_sec_r;
        res_usec   <= est_usec_r;
        res_offset <= last_offset;
        res_drift  <= drift;
      end else begin
        res_sec    <= '0;
        res_usec   <= '0;
        res_offset <= off_new;
        res_drift  <= drift_new;
      end
    end
  end

  assign result.valid       = res_valid;
  assign result.est_sec     = res_sec;
  assign result.est_usec    = res_usec;
  assign result.offset_usec = res_offset;
  assign result.drift_now   = res_drift;

endmodule
